// File: hdl/bvg_pkg.sv
// ----------------------------------------------------------------------------
// bvg_pkg
// shared types, widths and codes of the backlash velocity gate
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int VEL_W   = 16;
  localparam int SLOP_W  = 16;
  localparam int CNT_W   = 17;
  localparam int PROD_W  = VEL_W + SLOP_W;
  localparam int DIGIT_W = 2;
  // multiplier digits and quotient digit pairs share one step count
  localparam int STEPS   = SLOP_W / DIGIT_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  localparam logic ACT_UPDATE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_FWD_OK   = 2'd0,
    PH_BWD_OK   = 2'd1,
    PH_FWD_SLOP = 2'd2,
    PH_BWD_SLOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } bvg_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bvg_sts_t;

endpackage

// File: hdl/bvg_if.sv
// ----------------------------------------------------------------------------
// bvg channel interfaces
// update, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bvg_upd_if import bvg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [VEL_W-1:0] velocity;
  modport source (output valid, action, velocity, input ready);
  modport sink   (input valid, action, velocity, output ready);
endinterface

interface bvg_res_if import bvg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] filtered_velocity;
  phase_t                  phase;
  modport source (output valid, filtered_velocity, phase, input ready);
  modport sink   (input valid, filtered_velocity, phase, output ready);
endinterface

interface bvg_cfg_if import bvg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/backlash_velocity_gate_core.sv
// ----------------------------------------------------------------------------
// backlash_velocity_gate_core
// backlash phase tracker with velocity scaling by slop recovery fraction
// ----------------------------------------------------------------------------
// usage
//   upd carries one item per sample: action (update or restart) and a signed
//   q15 velocity. an update item yields one item on res: the velocity scaled
//   by min(count, slop_ticks) / slop_ticks, truncated toward zero, and the
//   phase after the update. a restart item forces forward ok, keeps the tick
//   count and yields nothing. cfg writes slop_ticks and is always ready; the
//   user must write it only while idle, as the core does not enforce that.
// timing
//   the scale unit works two bits a cycle: it multiplies, then divides, then
//   the result moves to the output register. upd is ready again in the same
//   cycle that an update's result is loaded there, so no new update is taken
//   while one is being scaled. restart items need no scale unit.
// stalls and reset
//   a result waits in the output register while res.ready is low; one more
//   update is accepted and computed meanwhile and then holds in the scale
//   unit. rst (synchronous) clears phase, count, slop_ticks and all valids.
// ----------------------------------------------------------------------------
module backlash_velocity_gate_core import bvg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bvg_upd_if.sink  upd,
  bvg_res_if.source res,
  bvg_cfg_if.sink  cfg
);

  logic [SLOP_W-1:0] slop;
  phase_t            phase;
  logic [CNT_W-1:0]  cnt;

  // pending item fields, held while the scale unit runs
  logic              pend_bypass;
  logic              pend_neg;
  logic [VEL_W-1:0]  pend_raw;
  phase_t            pend_phase;

  bvg_ctl_t          ctl;
  bvg_sts_t          sts;
  logic [VEL_W-1:0]  quot;

  logic              upd_acc;
  logic              out_load;
  logic [VEL_W-1:0]  vel_u;
  logic              neg, pos;
  logic [CNT_W-1:0]  cnt_inc, cnt_upd;
  phase_t            phase_upd;
  logic              past_slop;
  logic [VEL_W-1:0]  mag;
  logic [SLOP_W-1:0] mult;
  logic [VEL_W-1:0]  scaled;

  assign cfg.ready = 1'b1;
  assign upd.ready = !sts.busy;
  assign upd_acc   = upd.valid && upd.ready;

  // phase and count update for one tick
  always_comb begin
    vel_u     = upd.velocity;
    neg       = vel_u[VEL_W-1];
    pos       = !neg && (vel_u != '0);
    cnt_inc   = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    past_slop = (cnt_inc > {1'b0, slop});
    cnt_upd   = cnt_inc;
    phase_upd = phase;
    case (phase)
      PH_BWD_OK: begin
        if (pos) begin
          cnt_upd   = '0;
          phase_upd = PH_FWD_SLOP;
        end
      end
      PH_FWD_OK: begin
        if (neg) begin
          cnt_upd   = '0;
          phase_upd = PH_BWD_SLOP;
        end
      end
      PH_BWD_SLOP: begin
        if (pos) begin
          cnt_upd   = '0;
          phase_upd = PH_FWD_SLOP;
        end else if (past_slop) begin
          phase_upd = PH_BWD_OK;
        end
      end
      default: begin
        if (neg) begin
          cnt_upd   = '0;
          phase_upd = PH_BWD_SLOP;
        end else if (past_slop) begin
          phase_upd = PH_FWD_OK;
        end
      end
    endcase
    // min(count, slop) seen through the updated count
    mult = (cnt_upd > {1'b0, slop}) ? slop : cnt_upd[SLOP_W-1:0];
    mag  = neg ? (~vel_u + 1'b1) : vel_u;
  end

  always_comb begin
    out_load  = sts.done && (!res.valid || res.ready);
    ctl.start = upd_acc && (upd.action == ACT_UPDATE);
    ctl.take  = out_load;
    scaled    = pend_neg ? (~quot + 1'b1) : quot;
  end

  bvg_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .mag     (mag),
    .mult    (mult),
    .divisor (slop),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slop      <= '0;
      phase     <= PH_FWD_OK;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (cfg.valid) slop <= cfg.data;
      if (upd_acc) begin
        if (upd.action == ACT_RESTART) begin
          phase <= PH_FWD_OK;
        end else begin
          phase <= phase_upd;
          cnt   <= cnt_upd;
        end
      end
      if (out_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pend_bypass <= (slop == '0);
      pend_neg    <= neg;
      pend_raw    <= vel_u;
      pend_phase  <= phase_upd;
    end
    if (out_load) begin
      res.filtered_velocity <= pend_bypass ? pend_raw : scaled;
      res.phase             <= pend_phase;
    end
  end

`ifndef NO_ASSERTIONS
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    upd_acc && upd.action == ACT_UPDATE |=> sts.busy && !upd.ready)
    else $error("update item did not start the scale unit");
  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    upd_acc && upd.action == ACT_RESTART |=> phase == PH_FWD_OK && $stable(cnt))
    else $error("restart item did not reset phase or changed count");
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    sts.done && !res.valid |=> res.valid && !sts.done)
    else $error("finished result not moved to output register");
`endif

endmodule

// File: hdl/bvg_scale.sv
// ----------------------------------------------------------------------------
// bvg_scale
// digit-serial mag * mult / divisor, two bits per cycle, quotient fits VEL_W
// ----------------------------------------------------------------------------
module bvg_scale import bvg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bvg_ctl_t          ctl,
  output bvg_sts_t          sts,
  input  logic [VEL_W-1:0]  mag,
  input  logic [SLOP_W-1:0] mult,
  input  logic [SLOP_W-1:0] divisor,
  output logic [VEL_W-1:0]  quot
);

  scale_state_t        state, state_next;
  logic [STEP_W-1:0]   step;
  logic [VEL_W-1:0]    mag_r;
  logic [VEL_W+1:0]    mag3_r;
  logic [SLOP_W-1:0]   mult_sr;
  logic [SLOP_W-1:0]   div_r;
  logic [PROD_W-1:0]   acc;

  logic [VEL_W+1:0]    addend;
  logic [PROD_W-1:0]   mul_sum;
  logic [SLOP_W:0]     t1, t2, d_ext;
  logic                ge1, ge2;
  logic [SLOP_W-1:0]   r1, r2;
  logic [PROD_W-1:0]   div_next;

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (ctl.start) state_next = SC_MUL;
      SC_MUL:  if (step == STEP_LAST) state_next = SC_DIV;
      SC_DIV:  if (step == STEP_LAST) state_next = SC_DONE;
      SC_DONE: if (ctl.take) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (state != SC_IDLE);
    sts.done = (state == SC_DONE);
  end

  // multiply: msb-first radix-4 shift and add
  always_comb begin
    case (mult_sr[SLOP_W-1 -: DIGIT_W])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, mag_r};
      2'd2:    addend = {1'b0, mag_r, 1'b0};
      default: addend = mag3_r;
    endcase
    mul_sum = {acc[PROD_W-3:0], 2'b00} + {{(PROD_W-VEL_W-2){1'b0}}, addend};
  end

  // divide: two restoring steps, remainder high, quotient shifts in low
  always_comb begin
    d_ext    = {1'b0, div_r};
    t1       = {acc[PROD_W-1:VEL_W], acc[VEL_W-1]};
    ge1      = (t1 >= d_ext);
    r1       = ge1 ? SLOP_W'(t1 - d_ext) : t1[SLOP_W-1:0];
    t2       = {r1, acc[VEL_W-2]};
    ge2      = (t2 >= d_ext);
    r2       = ge2 ? SLOP_W'(t2 - d_ext) : t2[SLOP_W-1:0];
    div_next = {r2, acc[VEL_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == SC_MUL || state == SC_DIV) step <= step + 1'b1;
      else step <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SC_IDLE && ctl.start) begin
      mag_r   <= mag;
      mag3_r  <= {2'b00, mag} + {1'b0, mag, 1'b0};
      mult_sr <= mult;
      div_r   <= divisor;
      acc     <= '0;
    end else if (state == SC_MUL) begin
      acc     <= mul_sum;
      mult_sr <= {mult_sr[SLOP_W-3:0], 2'b00};
    end else if (state == SC_DIV) begin
      acc     <= div_next;
    end
  end

  assign quot = acc[VEL_W-1:0];

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> state == SC_IDLE)
    else $error("scale unit started while busy");
  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    state == SC_MUL && step == STEP_LAST |=> state == SC_DIV && step == '0)
    else $error("multiply phase did not hand over to divide");
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    state == SC_DONE && div_r != '0 && mult_sr == '0 |-> quot <= mag_r)
    else $error("scaled magnitude exceeds input magnitude");
`endif

endmodule

// File: bench/backlash_velocity_gate_core_tb.sv
// ----------------------------------------------------------------------------
// backlash_velocity_gate_core_tb
// self-checking bench: a queue-fed sample driver, a random-stall result sink
// and a clocked monitor that predicts phase and scaled velocity per item
// ----------------------------------------------------------------------------
module backlash_velocity_gate_core_tb;
  import bvg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 280;
  // one-way run length at the widest slop window
  localparam int WIDE_ITEMS     = 40;

  typedef struct {
    logic                    action;
    logic signed [VEL_W-1:0] velocity;
  } sample_item_t;

  typedef struct {
    logic signed [VEL_W-1:0] velocity;
    phase_t                  phase;
  } gate_result_t;

  logic clk;
  logic rst;

  bvg_upd_if upd ();
  bvg_res_if res ();
  bvg_cfg_if cfg ();

  backlash_velocity_gate_core uut (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .res (res),
    .cfg (cfg)
  );

  // pending samples, and expected results in order of acceptance
  sample_item_t sample_queue[$];
  gate_result_t expected_filtered[$];

  // shadow of the gate: phase, ticks since reversal, slop setting
  phase_t            gate_phase;
  logic [CNT_W-1:0]  tick_count;
  logic [SLOP_W-1:0] slop_setting;

  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  logic upd_taken      = 1'b0;
  logic hold_samples   = 1'b0;
  logic no_idle        = 1'b0;

  int send_gap   = 0;
  int send_calm  = 0;
  int sink_stall = 0;
  int sink_calm  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // nonzero velocity of the given sign, with the extremes showing up often
  function automatic logic signed [VEL_W-1:0] pick_velocity(input bit negative);
    int unsigned mag;
    case ($urandom_range(0, 9))
      0: mag = 1;
      1: mag = negative ? 32768 : 32767;
      default: mag = $urandom_range(1, 32767);
    endcase
    return negative ? -(VEL_W'(mag)) : VEL_W'(mag);
  endfunction

  // one update step of the gate: count, phase move, then scaled output
  function automatic gate_result_t advance_gate(input logic signed [VEL_W-1:0] vel);
    gate_result_t     r;
    logic             neg;
    logic             pos;
    logic [CNT_W-1:0] used;
    logic [VEL_W:0]   mag;
    logic [PROD_W:0]  prod;
    logic [VEL_W:0]   quot;
    neg = vel[VEL_W-1];
    pos = !neg && (vel != '0);
    if (tick_count != CNT_MAX) tick_count = tick_count + 1'b1;
    case (gate_phase)
      PH_FWD_OK: begin
        if (neg) begin
          tick_count = '0;
          gate_phase = PH_BWD_SLOP;
        end
      end
      PH_BWD_OK: begin
        if (pos) begin
          tick_count = '0;
          gate_phase = PH_FWD_SLOP;
        end
      end
      PH_BWD_SLOP: begin
        if (pos) begin
          tick_count = '0;
          gate_phase = PH_FWD_SLOP;
        end else if (tick_count > slop_setting) begin
          gate_phase = PH_BWD_OK;
        end
      end
      default: begin
        if (neg) begin
          tick_count = '0;
          gate_phase = PH_BWD_SLOP;
        end else if (tick_count > slop_setting) begin
          gate_phase = PH_FWD_OK;
        end
      end
    endcase
    r.phase = gate_phase;
    if (slop_setting == '0) begin
      r.velocity = vel;
    end else begin
      // magnitude of the sample, -32768 included
      mag  = neg ? {1'b0, -vel} : {1'b0, vel};
      used = (tick_count < CNT_W'(slop_setting)) ? tick_count : CNT_W'(slop_setting);
      prod = mag * used;
      quot = prod / slop_setting;
      r.velocity = neg ? -quot[VEL_W-1:0] : quot[VEL_W-1:0];
    end
    return r;
  endfunction

  task automatic push_update(input logic signed [VEL_W-1:0] vel);
    sample_item_t s;
    s.action   = ACT_UPDATE;
    s.velocity = vel;
    sample_queue.push_back(s);
  endtask

  task automatic push_restart();
    sample_item_t s;
    s.action   = ACT_RESTART;
    s.velocity = VEL_W'($urandom);
    sample_queue.push_back(s);
  endtask

  // wait until nothing is pending or in flight, then let restarts settle
  task automatic wait_idle();
    while (sample_queue.size() != 0 || upd.valid || expected_filtered.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_slop(input logic [SLOP_W-1:0] value);
    @(negedge clk);
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // same-sign runs sized around the slop window so the phases cycle, plus
  // restarts and raw noise samples
  task automatic queue_random(input int count, input logic [SLOP_W-1:0] slop);
    int n;
    int len;
    int cap;
    bit negative;
    n   = 0;
    cap = (slop > 10) ? 24 : 2 * slop + 4;
    while (n < count) begin
      case ($urandom_range(0, 99)) inside
        [0:7]: begin
          push_restart();
          n++;
        end
        [8:15]: begin
          push_update(VEL_W'($urandom));
          n++;
        end
        default: begin
          negative = $urandom_range(0, 1);
          len      = $urandom_range(1, cap);
          for (int i = 0; i < len && n < count; i++) begin
            if ($urandom_range(0, 19) == 0) push_update('0);
            else push_update(pick_velocity(negative));
            n++;
          end
        end
      endcase
    end
  endtask

  // one random phase at a fixed slop setting; halfway through, the sender
  // holds off until every expected result is back
  task automatic run_random_phase(input logic [SLOP_W-1:0] slop, input int count);
    write_slop(slop);
    queue_random(count, slop);
    while (sample_queue.size() > count / 2) @(negedge clk);
    hold_samples = 1'b1;
    while (upd.valid || expected_filtered.size() != 0) @(posedge clk);
    hold_samples = 1'b0;
    wait_idle();
  endtask

  // sample driver: presents the next queued item once the current one is taken
  always @(negedge clk) begin : drive_samples
    sample_item_t s;
    logic         next_valid;
    next_valid = upd.valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!upd.valid || upd_taken) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!hold_samples && sample_queue.size() > 0) begin
        s = sample_queue.pop_front();
        upd.action   <= s.action;
        upd.velocity <= s.velocity;
        next_valid = 1'b1;
        // quiet stretches with back-to-back items between the random gaps
        if (no_idle) begin
          send_gap = 0;
        end else if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 150);
        end
      end
    end
    upd.valid <= next_valid;
  end

  // result sink: random stalls started on any cycle, with stall-free stretches
  always @(negedge clk) begin : drive_ready
    logic next_ready;
    int   r;
    if (rst) begin
      next_ready = 1'b0;
    end else if (no_idle) begin
      next_ready = 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      next_ready = 1'b0;
    end else if (sink_calm > 0) begin
      sink_calm--;
      next_ready = 1'b1;
    end else begin
      next_ready = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        next_ready = 1'b0;
        sink_stall = pick_gap();
      end else if (r < 10) begin
        sink_calm = $urandom_range(100, 400);
      end
    end
    res.ready <= next_ready;
  end

  // monitor: checks results, tracks config writes, predicts accepted items
  always @(posedge clk) begin : monitor
    gate_result_t want;
    logic         progress;
    if (rst) begin
      gate_phase   = PH_FWD_OK;
      tick_count   = '0;
      slop_setting = '0;
      upd_taken    = 1'b0;
      idle_cycles  = 0;
    end else begin
      progress = 1'b0;
      if (res.valid && res.ready) begin
        progress = 1'b1;
        if (expected_filtered.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: velocity %0d phase %0d",
                     res.filtered_velocity, res.phase);
          mismatch_count++;
        end else begin
          want = expected_filtered.pop_front();
          if (res.filtered_velocity !== want.velocity || res.phase !== want.phase) begin
            if (mismatch_count < 10)
              $display("mismatch: expected velocity %0d phase %0d, got velocity %0d phase %0d",
                       want.velocity, want.phase, res.filtered_velocity, res.phase);
            mismatch_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        progress     = 1'b1;
        slop_setting = cfg.data;
      end
      upd_taken = upd.valid && upd.ready;
      if (upd_taken) begin
        progress = 1'b1;
        // restart forces forward ok and keeps the count; no result
        if (upd.action == ACT_RESTART) gate_phase = PH_FWD_OK;
        else expected_filtered.push_back(advance_gate(upd.velocity));
      end
      // watchdog on cycles with no handshake at all
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    upd.valid    = 1'b0;
    upd.action   = ACT_UPDATE;
    upd.velocity = '0;
    res.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero slop from reset: velocity passes through, phases still move
    push_update(16'sd32767);
    push_update(-16'sd32768);  // reversal out of forward ok
    push_update(16'sd0);       // zero never reverses; count past slop
    push_update(16'sd1);       // backward ok to forward slop
    push_update(-16'sd1);      // forward slop straight to backward slop
    push_restart();
    wait_idle();

    // short slop window: scaling by count/3 and recovery to the ok phases
    write_slop(16'd3);
    push_update(-16'sd20000);  // into backward slop, count cleared
    push_update(-16'sd20000);
    push_update(16'sd0);
    push_update(-16'sd32768);  // count at slop, full scale
    push_update(-16'sd7);      // count above slop: backward ok
    push_update(16'sd0);
    push_update(16'sd12345);   // backward ok to forward slop
    push_update(16'sd30001);
    push_restart();            // forward ok with count kept
    push_update(-16'sd3);
    push_update(16'sd32767);   // backward slop to forward slop
    push_update(-16'sd100);    // forward slop to backward slop
    push_update(16'sd5);
    push_update(16'sd32767);
    push_update(16'sd32767);
    push_update(16'sd32767);
    push_update(16'sd32767);   // back to forward ok
    wait_idle();

    // widest slop and a long one-way run that stays inside the slop window
    no_idle = 1'b1;
    write_slop(16'hFFFF);
    push_restart();
    for (int i = 0; i < WIDE_ITEMS; i++) begin
      if ($urandom_range(0, 15) == 0) push_update('0);
      else push_update(pick_velocity(1'b0));
    end
    push_update(pick_velocity(1'b1));
    push_update(pick_velocity(1'b1));
    push_update(pick_velocity(1'b0));
    wait_idle();
    no_idle = 1'b0;

    // random phases over a spread of slop settings
    run_random_phase(16'd1, PHASE_ITEMS);
    run_random_phase(SLOP_W'($urandom_range(3, 12)), PHASE_ITEMS);
    run_random_phase(16'd2, PHASE_ITEMS);
    run_random_phase(SLOP_W'($urandom_range(13, 40)), PHASE_ITEMS);
    run_random_phase(SLOP_W'($urandom_range(0, 65535)), PHASE_ITEMS);
    run_random_phase(16'd0, PHASE_ITEMS);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
